[hdl/ghp_pkg.sv]
package ghp_pkg;

    localparam int DEF_POOL_SLOTS = 256;
    localparam int DEF_INDEX_BITS = 20;
    localparam int DEF_COUNT_BITS = 16;

    localparam int HANDLE_W = 32;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int REF_W    = 16;
    localparam int FREED_W  = 9;

    localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADDREF  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COLLECT = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_STALE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SWEEP,
        ST_FINISH
    } ghp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic pop;
        logic sweep;
        logic finish;
    } ghp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_pop;
        logic in_collect;
        logic sweep_busy;
        logic out_busy;
    } ghp_stat_t;

endpackage

[hdl/ghp_ram.sv]
module ghp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/ghp_ctrl.sv]
module ghp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ghp_pkg::ghp_stat_t  stat,
    output ghp_pkg::ghp_cmd_t   cmd
);

    import ghp_pkg::*;

    ghp_state_t state_reg;
    ghp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.in_collect)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (stat.in_pop)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_POP:
            begin
                state_next = ST_FINISH;
            end
            ST_SWEEP:
            begin
                if (!stat.sweep_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.accept = in_valid;
            end
            ST_POP:
            begin
                cmd.pop = 1'b1;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = !stat.out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[hdl/ghp_datapath.sv]
module ghp_datapath #(
    parameter int POOL_SLOTS = 256,
    parameter int INDEX_BITS = 20,
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ghp_pkg::ghp_cmd_t                 cmd,
    output ghp_pkg::ghp_stat_t                stat,
    input  logic [ghp_pkg::REQ_W-1:0]         req_type,
    input  logic [ghp_pkg::HANDLE_W-1:0]      handle_in,
    input  logic                              mark_loaded,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [ghp_pkg::STATUS_W-1:0]      status,
    output logic [ghp_pkg::HANDLE_W-1:0]      handle_out,
    output logic [ghp_pkg::REF_W-1:0]         ref_count,
    output logic                              loaded_out,
    output logic [ghp_pkg::FREED_W-1:0]       freed_count
);

    import ghp_pkg::*;

    localparam int SLOT_W  = $clog2(POOL_SLOTS);
    localparam int FILL_W  = SLOT_W + 1;
    localparam int GEN_W   = HANDLE_W - INDEX_BITS;
    localparam int ENTRY_W = GEN_W + 1 + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(POOL_SLOTS);

    // Control state.
    logic [FILL_W-1:0]     free_depth_reg, free_depth_next;
    logic [FILL_W-1:0]     in_use_reg, in_use_next;
    logic [COUNT_BITS-1:0] slot0_cnt_reg, slot0_cnt_next;
    logic                  pipe_valid_reg, pipe_valid_next;
    logic                  out_valid_reg, out_valid_next;

    // Request and result payload.
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [GEN_W-1:0]      gen_reg, gen_next;
    logic                  mark_reg, mark_next;
    logic [SLOT_W-1:0]     target_reg, target_next;
    logic [FILL_W-1:0]     sweep_addr_reg, sweep_addr_next;
    logic [SLOT_W-1:0]     pipe_addr_reg, pipe_addr_next;
    logic [FILL_W-1:0]     freed_reg, freed_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [HANDLE_W-1:0]   handle_reg, handle_next;
    logic [REF_W-1:0]      ref_reg, ref_next;
    logic                  loaded_reg, loaded_next;
    logic [FREED_W-1:0]    freed_out_reg, freed_out_next;

    // Memory ports.
    logic                  slot_wr_en;
    logic [SLOT_W-1:0]     slot_wr_addr;
    logic [ENTRY_W-1:0]    slot_wr_data;
    logic                  slot_rd_en;
    logic [SLOT_W-1:0]     slot_rd_addr;
    logic [ENTRY_W-1:0]    slot_rd_data;
    logic                  stack_wr_en;
    logic [SLOT_W-1:0]     stack_wr_addr;
    logic [SLOT_W-1:0]     stack_rd_addr;
    logic [SLOT_W-1:0]     stack_rd_data;

    logic [FILL_W-1:0]     depth_less_one;
    logic                  sweep_issue;
    logic                  sweep_free;
    logic [GEN_W-1:0]      rd_gen;
    logic                  rd_loaded;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  target_zero;
    logic [GEN_W-1:0]      cur_gen;
    logic                  cur_loaded;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic                  hit;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [GEN_W-1:0]      new_gen;

    ghp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (slot_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (slot_rd_data)
    );

    ghp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (POOL_SLOTS)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stack_wr_en),
        .wr_addr (stack_wr_addr),
        .wr_data (pipe_addr_reg),
        .rd_en   (cmd.accept),
        .rd_addr (stack_rd_addr),
        .rd_data (stack_rd_data)
    );

    assign rd_gen    = slot_rd_data[ENTRY_W-1 -: GEN_W];
    assign rd_loaded = slot_rd_data[COUNT_BITS];
    assign rd_cnt    = slot_rd_data[COUNT_BITS-1:0];

    assign depth_less_one = free_depth_reg - FILL_W'(1);
    assign stack_rd_addr  = depth_less_one[SLOT_W-1:0];

    assign sweep_issue = cmd.sweep && (sweep_addr_reg < in_use_reg);
    // A swept slot is freed when it is loaded but nobody holds it.
    assign sweep_free  = pipe_valid_reg && rd_loaded && (rd_cnt == '0);

    assign stack_wr_en   = sweep_free && (free_depth_reg < FILL_LIMIT);
    assign stack_wr_addr = free_depth_reg[SLOT_W-1:0];

    // Slot zero never lives in memory; its count is held in a register.
    assign target_zero = (target_reg == '0);
    assign cur_gen     = target_zero ? '0 : rd_gen;
    assign cur_loaded  = target_zero ? 1'b0 : rd_loaded;
    assign cur_cnt     = target_zero ? slot0_cnt_reg : rd_cnt;
    assign hit = (HANDLE_W'(idx_reg) < HANDLE_W'(in_use_reg)) && (cur_gen == gen_reg);
    assign new_gen = cur_gen + GEN_W'(1);

    always_comb
    begin
        new_cnt = cur_cnt;
        case (req_reg)
            REQ_ADDREF:
            begin
                if (cur_cnt != CNT_MAX)
                begin
                    new_cnt = cur_cnt + COUNT_BITS'(1);
                end
            end
            REQ_RELEASE:
            begin
                if (cur_cnt != '0)
                begin
                    new_cnt = cur_cnt - COUNT_BITS'(1);
                end
            end
            default:
            begin
                new_cnt = cur_cnt;
            end
        endcase
    end

    assign slot_rd_en = cmd.accept || cmd.pop || sweep_issue;

    always_comb
    begin
        if (cmd.pop)
        begin
            slot_rd_addr = stack_rd_data;
        end
        else if (cmd.sweep)
        begin
            slot_rd_addr = sweep_addr_reg[SLOT_W-1:0];
        end
        else
        begin
            slot_rd_addr = handle_in[SLOT_W-1:0];
        end
    end

    always_comb
    begin
        free_depth_next = free_depth_reg;
        in_use_next     = in_use_reg;
        slot0_cnt_next  = slot0_cnt_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        gen_next        = gen_reg;
        mark_next       = mark_reg;
        target_next     = target_reg;
        sweep_addr_next = sweep_addr_reg;
        pipe_addr_next  = pipe_addr_reg;
        pipe_valid_next = sweep_issue;
        freed_next      = freed_reg;
        status_next     = status_reg;
        handle_next     = handle_reg;
        ref_next        = ref_reg;
        loaded_next     = loaded_reg;
        freed_out_next  = freed_out_reg;
        slot_wr_en      = 1'b0;
        slot_wr_addr    = target_reg;
        slot_wr_data    = {cur_gen, cur_loaded, new_cnt};

        if (cmd.accept)
        begin
            req_next        = req_type;
            idx_next        = handle_in[INDEX_BITS-1:0];
            gen_next        = handle_in[HANDLE_W-1:INDEX_BITS];
            mark_next       = mark_loaded;
            target_next     = handle_in[SLOT_W-1:0];
            sweep_addr_next = FILL_W'(1);
            freed_next      = '0;
        end

        if (cmd.pop)
        begin
            target_next = stack_rd_data;
        end

        if (sweep_issue)
        begin
            sweep_addr_next = sweep_addr_reg + FILL_W'(1);
            pipe_addr_next  = sweep_addr_reg[SLOT_W-1:0];
        end

        if (sweep_free)
        begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = pipe_addr_reg;
            slot_wr_data = {rd_gen + GEN_W'(1), 1'b0, rd_cnt};
            freed_next   = freed_reg + FILL_W'(1);
            if (free_depth_reg < FILL_LIMIT)
            begin
                free_depth_next = free_depth_reg + FILL_W'(1);
            end
        end

        if (cmd.finish)
        begin
            status_next    = STAT_STALE;
            handle_next    = '0;
            ref_next       = '0;
            loaded_next    = 1'b0;
            freed_out_next = '0;
            case (req_reg) inside
                REQ_ALLOC:
                begin
                    if (free_depth_reg != '0)
                    begin
                        free_depth_next = depth_less_one;
                        slot_wr_en      = 1'b1;
                        slot_wr_data    = {new_gen, mark_reg, COUNT_BITS'(1)};
                        status_next     = STAT_OK;
                        handle_next     = {new_gen, INDEX_BITS'(target_reg)};
                        ref_next        = REF_W'(1);
                        loaded_next     = mark_reg;
                    end
                    else if (in_use_reg < FILL_LIMIT)
                    begin
                        in_use_next  = in_use_reg + FILL_W'(1);
                        slot_wr_en   = 1'b1;
                        slot_wr_addr = in_use_reg[SLOT_W-1:0];
                        slot_wr_data = {GEN_W'(1), mark_reg, COUNT_BITS'(1)};
                        status_next  = STAT_OK;
                        handle_next  = {GEN_W'(1), INDEX_BITS'(in_use_reg)};
                        ref_next     = REF_W'(1);
                        loaded_next  = mark_reg;
                    end
                    else
                    begin
                        status_next = STAT_FULL;
                    end
                end
                REQ_ADDREF, REQ_RELEASE, REQ_QUERY:
                begin
                    if (hit)
                    begin
                        if (target_zero)
                        begin
                            slot0_cnt_next = new_cnt;
                        end
                        else
                        begin
                            slot_wr_en = 1'b1;
                        end
                        status_next = STAT_OK;
                        handle_next = {cur_gen, idx_reg};
                        ref_next    = REF_W'(new_cnt);
                        loaded_next = cur_loaded;
                    end
                end
                REQ_COLLECT:
                begin
                    status_next    = STAT_OK;
                    freed_out_next = FREED_W'(freed_reg);
                end
                default:
                begin
                    status_next = STAT_STALE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_depth_reg <= '0;
            in_use_reg     <= FILL_W'(1);
            slot0_cnt_reg  <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            free_depth_reg <= free_depth_next;
            in_use_reg     <= in_use_next;
            slot0_cnt_reg  <= slot0_cnt_next;
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        gen_reg        <= gen_next;
        mark_reg       <= mark_next;
        target_reg     <= target_next;
        sweep_addr_reg <= sweep_addr_next;
        pipe_addr_reg  <= pipe_addr_next;
        freed_reg      <= freed_next;
        status_reg     <= status_next;
        handle_reg     <= handle_next;
        ref_reg        <= ref_next;
        loaded_reg     <= loaded_next;
        freed_out_reg  <= freed_out_next;
    end

    assign stat.in_pop     = (req_type == REQ_ALLOC) && (free_depth_reg != '0);
    assign stat.in_collect = (req_type == REQ_COLLECT);
    assign stat.sweep_busy = (sweep_addr_reg < in_use_reg) || pipe_valid_reg;
    assign stat.out_busy   = out_valid_reg && out_stall;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign handle_out  = handle_reg;
    assign ref_count   = ref_reg;
    assign loaded_out  = loaded_reg;
    assign freed_count = freed_out_reg;

endmodule

[hdl/generational_handle_pool.sv]
// Channel   Handshake               Fields
// -------   ---------------------   -----------------------------------------------
// request   in_valid / in_stall     req_type, handle_in, mark_loaded
// result    out_valid / out_stall   status, handle_out, ref_count, loaded_out,
//                                   freed_count
//
// Addref, release, query and alloc of a fresh slot read the slot memory, then update
// it and register the result. Alloc from the free stack reads the stack memory
// before the slot. Collect reads the slots in use, one slot a cycle, through the
// slot memory's read port. Reset clears the counters and flags only; the fill count
// keeps unwritten slots unread, so there is no clearing pass. A stalled result holds
// the block in its last step.
module generational_handle_pool #(
    parameter int POOL_SLOTS = ghp_pkg::DEF_POOL_SLOTS,
    parameter int INDEX_BITS = ghp_pkg::DEF_INDEX_BITS,
    parameter int COUNT_BITS = ghp_pkg::DEF_COUNT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ghp_pkg::REQ_W-1:0]         req_type,
    input  logic [ghp_pkg::HANDLE_W-1:0]      handle_in,
    input  logic                              mark_loaded,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ghp_pkg::STATUS_W-1:0]      status,
    output logic [ghp_pkg::HANDLE_W-1:0]      handle_out,
    output logic [ghp_pkg::REF_W-1:0]         ref_count,
    output logic                              loaded_out,
    output logic [ghp_pkg::FREED_W-1:0]       freed_count
);

    import ghp_pkg::*;

    ghp_cmd_t  cmd;
    ghp_stat_t stat;

    ghp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ghp_datapath #(
        .POOL_SLOTS (POOL_SLOTS),
        .INDEX_BITS (INDEX_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .handle_in   (handle_in),
        .mark_loaded (mark_loaded),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status      (status),
        .handle_out  (handle_out),
        .ref_count   (ref_count),
        .loaded_out  (loaded_out),
        .freed_count (freed_count)
    );

endmodule
